// ===== rtl/gbr_pkg.sv =====
// ----------------------------------------------------------------------------
// gbr_pkg: shared types and constants of the 5x5 / ring 3x3 Gaussian blur
// Request payloads, window type, register map and border region codes.
// ----------------------------------------------------------------------------
`default_nettype none

package gbr_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned MAX_HEIGHT    = 4096;
  localparam int unsigned MIN_DIM       = 5;

  localparam int unsigned PIX_W        = 8;
  localparam int unsigned WIDTH_REG_W  = 12;
  localparam int unsigned HEIGHT_REG_W = 13;
  localparam int unsigned ROW_W        = 13;
  localparam int unsigned LINES        = 4;
  localparam int unsigned WIN          = 5;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic MODE_FLUSH = 1'b1;

  // register index is paddr bit 2 (registers at byte 0 and byte 4)
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    REGION_BORDER = 2'd0,
    REGION_RING   = 2'd1,
    REGION_INNER  = 2'd2
  } region_e;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] blurred_value;
    logic             frame_end;
  } out_item_t;

  // [row][column]; row 0 is the oldest line, column 4 the newest pixel
  typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] window_t;

  // one column of the four line buffers, line 0 the oldest
  typedef logic [LINES-1:0][PIX_W-1:0] line_col_t;

endpackage

`default_nettype wire

// ===== rtl/gaussian_blur_5x5_ring3x3_top.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_ring3x3_top: streaming 5x5 binomial blur
// Raster 8-bit gray pixels in, one blurred pixel out per request once the
// window is two rows and two pixels behind; outer border 0, next ring 3x3.
// ----------------------------------------------------------------------------
//
//  port group   direction  handshake             payload
//  -----------  ---------  --------------------  --------------------------
//  in           sink       in_valid_i/in_stall_o  in_data_i  (in_item_t)
//  out          source     out_valid_o/out_stall_i out_data_o (out_item_t)
//  cfg          slave      psel/penable/pready    paddr/pwdata/prdata
//
//  One request per clock sustained while the output does not stall. A request
//  is taken into the input stage, which also launches the line buffer read;
//  when that stage advances, the line buffer is written back, the window
//  shifts and the result register loads. Reset clears counters, window and
//  valid flags; line buffers are not cleared. A stalled output holds the
//  input stage only if the pending request produces a result.
//
`default_nettype none

module gaussian_blur_5x5_ring3x3_top import gbr_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  // pixel requests
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_item_t           in_data_i,
  // blurred pixels
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_item_t               out_data_o
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned XW = ((CW > WIDTH_REG_W) ? CW : WIDTH_REG_W) + 1;
  localparam int unsigned YW = ROW_W + 1;

  // ---------------- configuration registers ----------------
  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[2]))
        REG_IMAGE_WIDTH:  width_q  <= pwdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= pwdata[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_reg_e'(paddr[2]))
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(width_q);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(height_q);
      default: ;
    endcase
  end

  // Clamp frame size to 5..max.
  logic [WIDTH_REG_W-1:0]  dim_w;
  logic [HEIGHT_REG_W-1:0] dim_h;

  always_comb begin
    if (width_q < WIDTH_REG_W'(MIN_DIM)) begin
      dim_w = WIDTH_REG_W'(MIN_DIM);
    end else if (32'(width_q) > MAX_WIDTH) begin
      dim_w = WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      dim_w = width_q;
    end
    if (height_q < HEIGHT_REG_W'(MIN_DIM)) begin
      dim_h = HEIGHT_REG_W'(MIN_DIM);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      dim_h = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      dim_h = height_q;
    end
  end

  // ---------------- raster position counters ----------------
  logic [CW-1:0]    in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic             in_acc;
  logic             emit, in_last_col, out_last_col, out_last;
  logic [XW-1:0]    dim_wx;
  logic [YW-1:0]    dim_hx;
  region_e          region;

  assign in_acc = in_valid_i && !in_stall_o;
  assign dim_wx = XW'(dim_w);
  assign dim_hx = YW'(dim_h);

  always_comb begin
    // a result starts once the input is two rows and two pixels ahead
    emit         = (in_row_q > ROW_W'(2)) || (in_row_q == ROW_W'(2) && in_col_q >= CW'(2));
    in_last_col  = (XW'(in_col_q) + XW'(1)) >= dim_wx;
    out_last_col = (XW'(out_col_q) + XW'(1)) >= dim_wx;
    out_last     = out_last_col && ((YW'(out_row_q) + YW'(1)) >= dim_hx);

    if (out_col_q == '0 || out_row_q == '0 ||
        XW'(out_col_q) >= dim_wx - XW'(1) || YW'(out_row_q) >= dim_hx - YW'(1)) begin
      region = REGION_BORDER;
    end else if (out_col_q == CW'(1) || out_row_q == ROW_W'(1) ||
                 XW'(out_col_q) == dim_wx - XW'(2) || YW'(out_row_q) == dim_hx - YW'(2)) begin
      region = REGION_RING;
    end else begin
      region = REGION_INNER;
    end
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (in_acc) begin
      if (emit && out_last) begin
        // frame done: restart all positions
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else begin
        if (emit) begin
          if (out_last_col) begin
            out_col_d = '0;
            out_row_d = out_row_q + ROW_W'(1);
          end else begin
            out_col_d = out_col_q + CW'(1);
          end
        end
        if (in_last_col) begin
          in_col_d = '0;
          in_row_d = in_row_q + ROW_W'(1);
        end else begin
          in_col_d = in_col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // ---------------- input stage ----------------
  logic             s1_valid_q, s1_valid_d;
  logic [PIX_W-1:0] s1_pix_q;
  logic             s1_emit_q;
  logic             s1_last_q;
  region_e          s1_region_q;
  logic [CW-1:0]    s1_col_q;
  logic             s1_adv;

  // Hold the stage only when its result has nowhere to go.
  assign s1_adv     = s1_valid_q && (!s1_emit_q || !out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      // flush requests shift in zero
      s1_pix_q    <= (in_data_i.mode == MODE_FLUSH) ? '0 : in_data_i.pixel_value;
      s1_emit_q   <= emit;
      s1_last_q   <= emit && out_last;
      s1_region_q <= region;
      s1_col_q    <= in_col_q;
    end
  end

  // ---------------- line buffers ----------------
  line_col_t rd_col;
  line_col_t wr_col;

  // each line takes the value of the next younger one; the newest gets the pixel
  always_comb begin
    for (int k = 0; k < LINES - 1; k++) begin
      wr_col[k] = rd_col[k+1];
    end
    wr_col[LINES-1] = s1_pix_q;
  end

  gbr_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_col),
    .rd_en_i   (in_acc),
    .rd_addr_i (in_col_q),
    .rd_data_o (rd_col)
  );

  // ---------------- window and kernel ----------------
  window_t          win_q, win_d;
  logic [PIX_W-1:0] blur_pix;

  // shift left, new column enters at the right
  always_comb begin
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN - 1; c++) begin
        win_d[r][c] = win_q[r][c+1];
      end
    end
    for (int r = 0; r < LINES; r++) begin
      win_d[r][WIN-1] = rd_col[r];
    end
    win_d[WIN-1][WIN-1] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      win_q <= win_d;
    end
  end

  gbr_kernel u_kernel (
    .win_i    (win_d),
    .region_i (s1_region_q),
    .pixel_o  (blur_pix)
  );

  // ---------------- result register ----------------
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_emit_q) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      out_data_q.blurred_value <= blur_pix;
      out_data_q.frame_end     <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------- assertions ----------------
  // the last pixel of a frame is a corner, hence border
  a_frame_end_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |-> out_data_o.blurred_value == '0)
    else $error("frame end pixel is not zero");

  a_frame_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && emit && out_last |=>
      in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0)
    else $error("counters not restarted after frame end");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_emit_q && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_emit_q |=> out_valid_o && out_data_o.frame_end == $past(s1_last_q))
    else $error("result register not loaded");

endmodule

`default_nettype wire

// ===== rtl/gbr_line_mem.sv =====
// ----------------------------------------------------------------------------
// gbr_line_mem: line buffer memory
// One word per image column holding that column of all four lines.
// One write port, one read port, registered read data; a read of the word
// written at the same edge returns the new word.
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_line_mem import gbr_pkg::*; #(
  parameter int unsigned DEPTH = MAX_WIDTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic      clk_i,
  input  wire logic      wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire line_col_t wr_data_i,
  input  wire logic      rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output line_col_t      rd_data_o
);

  line_col_t mem_q [DEPTH];
  line_col_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      // pass the word being written straight through
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/gbr_kernel.sv =====
// ----------------------------------------------------------------------------
// gbr_kernel: blur kernel datapath
// Separable binomial sums: 5x5 [1 4 6 4 1] / 256 or center 3x3 [1 2 1] / 16.
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_kernel import gbr_pkg::*; (
  input  wire window_t          win_i,
  input  wire region_e          region_i,
  output logic [PIX_W-1:0]      pixel_o
);

  logic [11:0] cs5 [WIN];
  logic [9:0]  cs3 [3];
  logic [15:0] sum5;
  logic [11:0] sum3;

  always_comb begin
    // vertical pass per column
    for (int c = 0; c < WIN; c++) begin
      cs5[c] = 12'(win_i[0][c]) + (12'(win_i[1][c]) << 2) + 12'(win_i[2][c]) * 12'd6
             + (12'(win_i[3][c]) << 2) + 12'(win_i[4][c]);
    end
    for (int c = 0; c < 3; c++) begin
      cs3[c] = 10'(win_i[1][c+1]) + (10'(win_i[2][c+1]) << 1) + 10'(win_i[3][c+1]);
    end
    // horizontal pass
    sum5 = 16'(cs5[0]) + (16'(cs5[1]) << 2) + 16'(cs5[2]) * 16'd6
         + (16'(cs5[3]) << 2) + 16'(cs5[4]);
    sum3 = 12'(cs3[0]) + (12'(cs3[1]) << 1) + 12'(cs3[2]);
  end

  always_comb begin
    case (region_i)
      REGION_RING:  pixel_o = sum3[11:4];
      REGION_INNER: pixel_o = sum5[15:8];
      default:      pixel_o = '0;
    endcase
  end

endmodule

`default_nettype wire
